@@ rtl/gap_framed_command_receiver_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the gap framed command receiver
// Concurrent checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GAP_FRAMED_COMMAND_RECEIVER_MACROS_SVH
`define GAP_FRAMED_COMMAND_RECEIVER_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define GFCR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gfcr check failed");
// antecedent implies consequent in the next cycle
`define GFCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gfcr check failed");
`else
`define GFCR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GFCR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/gfcr_pkg.sv @@
// ----------------------------------------------------------------------------
// gfcr_pkg
// Types and constants shared by the gap framed command receiver.
// ----------------------------------------------------------------------------
package gfcr_pkg;

    // input command codes
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_IDLE = 2'd1;
    localparam logic [1:0] CMD_ACK  = 2'd2;

    // result kind codes
    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_CMD  = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    // configuration register indexes
    localparam logic REG_GAP_TICKS = 1'b0;
    localparam logic REG_MAX_LEN   = 1'b1;

    localparam logic [7:0] GAP_TICKS_RESET = 8'd10;
    localparam logic [7:0] MAX_LEN_RESET   = 8'd16;

    // protocol bytes
    localparam logic [7:0] SOH_BYTE   = 8'h01;
    localparam logic [7:0] NAK_BYTE   = 8'h7F;
    localparam logic [7:0] ACK_OFFSET = 8'h20;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        JOB_ACK  = 2'd0,
        JOB_NAK  = 2'd1,
        JOB_CMD  = 2'd2,
        JOB_FAIL = 2'd3
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] data;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

@@ rtl/gfcr_in_if.sv @@
// ----------------------------------------------------------------------------
// gfcr_in_if
// Input channel: received bytes, idle ticks and acknowledge requests.
// ----------------------------------------------------------------------------
interface gfcr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

@@ rtl/gfcr_out_if.sv @@
// ----------------------------------------------------------------------------
// gfcr_out_if
// Result channel: transmit bytes, received commands and failures.
// ----------------------------------------------------------------------------
interface gfcr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

@@ rtl/gap_framed_command_receiver.sv @@
// Reply jobs go through the job queue, then the reply sequencer's output register.
// Throughput: one item per cycle while the job queue has room; one result per cycle while
// result.ready is high; the reply sequencer sends an item's up to five results back to back.
// Reset (rst_n low, asynchronous): frame state, pending command and queue cleared,
// gap_ticks back to 10 and max_len back to 16.
// ----------------------------------------------------------------------------
// gap_framed_command_receiver
// Gap framed checksum receiver with ACK/NAK replies, top level.
// ----------------------------------------------------------------------------
module gap_framed_command_receiver #(
    parameter int QUEUE_DEPTH = gfcr_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    gfcr_in_if.sink    item,
    gfcr_out_if.source result,
    input  logic       wr_en,
    input  logic       wr_index,
    input  logic [7:0] wr_data
);

    logic [7:0] gap_reg;
    logic [7:0] max_len_reg;

    gfcr_pkg::queue_status_t q_status;
    gfcr_pkg::job_t          push_job;
    gfcr_pkg::job_t          head;
    logic                    push;
    logic                    pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg     <= gfcr_pkg::GAP_TICKS_RESET;
            max_len_reg <= gfcr_pkg::MAX_LEN_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                gfcr_pkg::REG_GAP_TICKS: gap_reg     <= wr_data;
                gfcr_pkg::REG_MAX_LEN:   max_len_reg <= wr_data;
                default:                 gap_reg     <= gap_reg;
            endcase
        end
    end

    gfcr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .gap_ticks(gap_reg),
        .max_len  (max_len_reg),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    gfcr_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .head    (head),
        .status  (q_status)
    );

    gfcr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .job     (head),
        .q_status(q_status),
        .pop     (pop),
        .result  (result)
    );

endmodule

@@ rtl/gfcr_front.sv @@
// ----------------------------------------------------------------------------
// gfcr_front
// Frame tracker: accepts items, keeps the frame state and queues reply jobs.
// ----------------------------------------------------------------------------
module gfcr_front (
    input  logic                  clk,
    input  logic                  rst_n,
    gfcr_in_if.sink               item,
    input  logic [7:0]            gap_ticks,
    input  logic [7:0]            max_len,
    input  gfcr_pkg::queue_status_t q_status,
    output logic                  push,
    output gfcr_pkg::job_t        push_job
);

    logic [7:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] prev_reg, prev_next;
    logic [7:0] second_reg, second_next;
    logic [7:0] pending_reg, pending_next;
    logic       ovf_reg, ovf_next;
    logic [7:0] idle_reg, idle_next;
    logic [8:0] idle_inc;
    logic       accept;

    assign item.ready = !q_status.full;
    assign accept     = item.valid && item.ready;
    assign idle_inc   = {1'b0, idle_reg} + 9'd1;

    always_comb
    begin
        count_next   = count_reg;
        sum_next     = sum_reg;
        prev_next    = prev_reg;
        second_next  = second_reg;
        pending_next = pending_reg;
        ovf_next     = ovf_reg;
        idle_next    = idle_reg;
        push         = 1'b0;
        push_job     = '{kind: gfcr_pkg::JOB_FAIL, data: second_reg};
        if (accept)
        begin
            unique case (item.command)
                gfcr_pkg::CMD_BYTE:
                begin
                    if (pending_reg == 8'd0)
                    begin
                        idle_next = 8'd0;
                        if (ovf_reg || count_reg >= max_len)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            if (count_reg != 8'd0)
                            begin
                                sum_next = sum_reg + prev_reg;
                            end
                            if (count_reg == 8'd1)
                            begin
                                second_next = item.data_byte;
                            end
                            prev_next  = item.data_byte;
                            count_next = count_reg + 8'd1;
                        end
                    end
                end
                gfcr_pkg::CMD_IDLE:
                begin
                    if (count_reg != 8'd0 || ovf_reg)
                    begin
                        if (idle_inc >= {1'b0, gap_ticks})
                        begin
                            // gap reached: close the frame
                            push = 1'b1;
                            if (ovf_reg)
                            begin
                                push_job.kind = gfcr_pkg::JOB_FAIL;
                            end
                            else if (prev_reg != sum_reg || count_reg < 8'd2)
                            begin
                                push_job.kind = gfcr_pkg::JOB_NAK;
                                pending_next  = 8'd0;
                            end
                            else
                            begin
                                push_job.kind = gfcr_pkg::JOB_CMD;
                                pending_next  = second_reg;
                            end
                            count_next = 8'd0;
                            sum_next   = 8'd0;
                            prev_next  = 8'd0;
                            ovf_next   = 1'b0;
                            idle_next  = 8'd0;
                        end
                        else
                        begin
                            idle_next = idle_inc[7:0];
                        end
                    end
                end
                gfcr_pkg::CMD_ACK:
                begin
                    push          = 1'b1;
                    push_job.kind = gfcr_pkg::JOB_ACK;
                    pending_next  = 8'd0;
                end
                default:
                begin
                    // unused code: no effect
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= 8'd0;
            sum_reg     <= 8'd0;
            prev_reg    <= 8'd0;
            second_reg  <= 8'd0;
            pending_reg <= 8'd0;
            ovf_reg     <= 1'b0;
            idle_reg    <= 8'd0;
        end
        else
        begin
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            prev_reg    <= prev_next;
            second_reg  <= second_next;
            pending_reg <= pending_next;
            ovf_reg     <= ovf_next;
            idle_reg    <= idle_next;
        end
    end

`include "gap_framed_command_receiver_macros.svh"

    `GFCR_ASSERT_SAME(a_push_only_on_accept, clk, rst_n, push, accept)
    `GFCR_ASSERT_NEXT(a_ovf_no_growth, clk, rst_n, ovf_reg && !push, count_reg == $past(count_reg))

endmodule

@@ rtl/gfcr_queue.sv @@
// ----------------------------------------------------------------------------
// gfcr_queue
// Small job queue between the frame tracker and the reply sequencer.
// ----------------------------------------------------------------------------
module gfcr_queue #(
    parameter int DEPTH = gfcr_pkg::QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  gfcr_pkg::job_t          push_job,
    input  logic                    pop,
    output gfcr_pkg::job_t          head,
    output gfcr_pkg::queue_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    gfcr_pkg::job_t mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

`include "gap_framed_command_receiver_macros.svh"

    `GFCR_ASSERT_SAME(a_no_push_when_full, clk, rst_n, status.full, !push)
    `GFCR_ASSERT_NEXT(a_count_grows, clk, rst_n, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1)

endmodule

@@ rtl/gfcr_back.sv @@
// ----------------------------------------------------------------------------
// gfcr_back
// Reply sequencer: expands each queued job into its result items.
// ----------------------------------------------------------------------------
module gfcr_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gfcr_pkg::job_t          job,
    input  gfcr_pkg::queue_status_t q_status,
    output logic                    pop,
    gfcr_out_if.source              result
);

    logic       valid_reg;
    logic [2:0] step_reg, step_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] value_reg, value_next;
    logic       last_reg, last_next;
    logic       job_valid;
    logic       load;
    logic [7:0] ack_byte;

    assign job_valid = !q_status.empty;
    assign load      = !valid_reg || result.ready;
    assign pop       = load && job_valid && last_next;
    assign ack_byte  = job.data + gfcr_pkg::ACK_OFFSET;

    always_comb
    begin
        kind_next  = gfcr_pkg::KIND_TX;
        value_next = 8'd0;
        last_next  = 1'b0;
        unique case (job.kind)
            gfcr_pkg::JOB_ACK:
            begin
                unique case (step_reg)
                    3'd0:    value_next = gfcr_pkg::SOH_BYTE;
                    3'd1:    value_next = ack_byte;
                    default: value_next = gfcr_pkg::SOH_BYTE + ack_byte;
                endcase
                last_next = (step_reg == 3'd2);
            end
            gfcr_pkg::JOB_NAK:
            begin
                unique case (step_reg)
                    3'd0: value_next = gfcr_pkg::SOH_BYTE;
                    3'd1: value_next = gfcr_pkg::NAK_BYTE;
                    3'd2: value_next = job.data;
                    3'd3: value_next = gfcr_pkg::SOH_BYTE + gfcr_pkg::NAK_BYTE + job.data;
                    default:
                    begin
                        kind_next = gfcr_pkg::KIND_FAIL;
                    end
                endcase
                last_next = (step_reg == 3'd4);
            end
            gfcr_pkg::JOB_CMD:
            begin
                kind_next  = gfcr_pkg::KIND_CMD;
                value_next = job.data;
                last_next  = 1'b1;
            end
            default:
            begin
                kind_next = gfcr_pkg::KIND_FAIL;
                last_next = 1'b1;
            end
        endcase
        step_next = last_next ? 3'd0 : step_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= 3'd0;
        end
        else if (load)
        begin
            valid_reg <= job_valid;
            if (job_valid)
            begin
                step_reg <= step_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && job_valid)
        begin
            kind_reg  <= kind_next;
            value_reg <= value_next;
            last_reg  <= last_next;
        end
    end

    assign result.valid = valid_reg;
    assign result.kind  = kind_reg;
    assign result.value = value_reg;
    assign result.last  = last_reg;

`include "gap_framed_command_receiver_macros.svh"

    `GFCR_ASSERT_SAME(a_mid_job_has_job, clk, rst_n, step_reg != 3'd0, job_valid)
    `GFCR_ASSERT_SAME(a_cmd_is_last, clk, rst_n, valid_reg && kind_reg == gfcr_pkg::KIND_CMD, last_reg)

endmodule

@@ test/gap_framed_command_receiver_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gap_framed_command_receiver_tb
// Self-checking bench: drives bytes, idle ticks and acknowledge requests with
// random handshake gaps, predicts every ACK/NAK byte, command and failure,
// and compares each result item in order across several register settings.
// ----------------------------------------------------------------------------
module gap_framed_command_receiver_tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } reply_t;

    class frame_reply_model;
        logic [7:0] gap_ticks;
        logic [7:0] max_len;
        logic [7:0] frame_count;
        logic [7:0] running_sum;
        logic [7:0] previous_byte;
        logic [7:0] second_byte;
        logic [7:0] pending_command;
        logic [7:0] idle_count;
        logic       overflowed;
        reply_t     due[$];
        reply_t     fresh[$];
        int         mismatches;

        function new();
            gap_ticks       = gfcr_pkg::GAP_TICKS_RESET;
            max_len         = gfcr_pkg::MAX_LEN_RESET;
            second_byte     = 8'h00;
            pending_command = 8'h00;
            mismatches      = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            frame_count   = 8'h00;
            running_sum   = 8'h00;
            previous_byte = 8'h00;
            overflowed    = 1'b0;
            idle_count    = 8'h00;
        endfunction

        function void set_reg(logic idx, logic [7:0] val);
            if (idx == gfcr_pkg::REG_GAP_TICKS)
                gap_ticks = val;
            else
                max_len = val;
        endfunction

        function void add(logic [1:0] kind, logic [7:0] value);
            reply_t r;
            r.kind  = kind;
            r.value = value;
            r.last  = 1'b0;
            fresh.push_back(r);
        endfunction

        function void close_frame();
            logic [7:0] nak_sum;
            nak_sum = gfcr_pkg::SOH_BYTE + gfcr_pkg::NAK_BYTE + second_byte;
            if (overflowed) begin
                add(gfcr_pkg::KIND_FAIL, 8'h00);
            end
            else if (previous_byte != running_sum || frame_count < 8'd2) begin
                add(gfcr_pkg::KIND_TX, gfcr_pkg::SOH_BYTE);
                add(gfcr_pkg::KIND_TX, gfcr_pkg::NAK_BYTE);
                add(gfcr_pkg::KIND_TX, second_byte);
                add(gfcr_pkg::KIND_TX, nak_sum);
                add(gfcr_pkg::KIND_FAIL, 8'h00);
                pending_command = 8'h00;
            end
            else begin
                pending_command = second_byte;
                add(gfcr_pkg::KIND_CMD, second_byte);
            end
            clear_frame();
        endfunction

        // one accepted input item -> zero or more expected result items
        function void take_item(logic [1:0] cmd, logic [7:0] b);
            logic [8:0] next_idle;
            logic [7:0] ack_cmd;
            fresh.delete();
            case (cmd)
                gfcr_pkg::CMD_BYTE: begin
                    if (pending_command == 8'h00) begin
                        idle_count = 8'h00;
                        if (overflowed || frame_count >= max_len) begin
                            overflowed = 1'b1;
                        end
                        else begin
                            if (frame_count >= 8'd1)
                                running_sum = running_sum + previous_byte;
                            if (frame_count == 8'd1)
                                second_byte = b;
                            previous_byte = b;
                            frame_count   = frame_count + 8'd1;
                        end
                    end
                end
                gfcr_pkg::CMD_IDLE: begin
                    if (frame_count > 8'd0 || overflowed) begin
                        next_idle = {1'b0, idle_count} + 9'd1;
                        if (next_idle >= {1'b0, gap_ticks})
                            close_frame();
                        else
                            idle_count = next_idle[7:0];
                    end
                end
                gfcr_pkg::CMD_ACK: begin
                    ack_cmd = second_byte + gfcr_pkg::ACK_OFFSET;
                    add(gfcr_pkg::KIND_TX, gfcr_pkg::SOH_BYTE);
                    add(gfcr_pkg::KIND_TX, ack_cmd);
                    add(gfcr_pkg::KIND_TX, gfcr_pkg::SOH_BYTE + ack_cmd);
                    pending_command = 8'h00;
                end
                default: ;
            endcase
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i])
                due.push_back(fresh[i]);
        endfunction

        function void match_reply(logic [1:0] kind, logic [7:0] value, logic last);
            reply_t want;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d value %02h last %0d",
                             kind, value, last);
            end
            else begin
                want = due.pop_front();
                if (kind !== want.kind || value !== want.value || last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected kind %0d value %02h last %0d,",
                                  " got kind %0d value %02h last %0d"},
                                 want.kind, want.value, want.last, kind, value, last);
                end
            end
        endfunction

        function int outstanding();
            return due.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       wr_en;
    logic       wr_index;
    logic [7:0] wr_data;

    gfcr_in_if  item_ch();
    gfcr_out_if result_ch();

    frame_reply_model model;
    int items_sent;
    int cycles = 0;
    bit src_quiet;
    bit snk_quiet;
    bit hold_quiet;

    gap_framed_command_receiver DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
        int pause;
        if ($urandom_range(0, 39) == 0)
            src_quiet = !src_quiet;
        pause = (src_quiet || hold_quiet) ? 0 : $urandom_range(0, 17);
        if (pause > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.command   <= cmd;
        item_ch.data_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (!item_ch.ready);
        model.take_item(cmd, b);
        items_sent++;
    endtask

    // block must be idle: wait for all results, then let silent items settle
    task automatic write_reg(input logic idx, input logic [7:0] val);
        item_ch.valid <= 1'b0;
        while (model.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        model.set_reg(idx, val);
    endtask

    task automatic configure(input logic [7:0] gap, input logic [7:0] len);
        write_reg(gfcr_pkg::REG_GAP_TICKS, gap);
        write_reg(gfcr_pkg::REG_MAX_LEN, len);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(gfcr_pkg::CMD_IDLE, 8'($urandom));
    endtask

    // len bytes; the last one is the checksum when good is set
    task automatic send_frame(input int len, input bit good);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'h00;
        for (int i = 0; i < len - 1; i++)
        begin
            b = 8'($urandom);
            sum = sum + b;
            send_item(gfcr_pkg::CMD_BYTE, b);
        end
        send_item(gfcr_pkg::CMD_BYTE, good ? sum : 8'($urandom));
    endtask

    function automatic int gap_len();
        return (model.gap_ticks == 8'd0) ? 1 : int'(model.gap_ticks);
    endfunction

    task automatic random_traffic(input int budget);
        int stop;
        int pick;
        int len;
        stop = items_sent + budget;
        while (items_sent < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                if (pick < 8 && model.max_len <= 8'd16)
                    len = int'(model.max_len) + $urandom_range(1, 3);
                else if (pick < 14)
                    len = 1;
                else
                    len = $urandom_range(2, 6);
                send_frame(len, $urandom_range(0, 3) != 0);
                // short gap: frame goes on with one more byte
                if ($urandom_range(0, 5) == 0)
                begin
                    if (gap_len() > 1)
                        send_ticks($urandom_range(1, gap_len() - 1));
                    send_item(gfcr_pkg::CMD_BYTE, 8'($urandom));
                end
                send_ticks(gap_len());
                if ($urandom_range(0, 4) != 0)
                    send_item(gfcr_pkg::CMD_ACK, 8'($urandom));
            end
            else
            begin
                send_item(2'($urandom_range(0, 3)), 8'($urandom));
            end
        end
    endtask

    initial
    begin : drain
        int stall;
        result_ch.ready = 1'b0;
        snk_quiet       = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                snk_quiet = !snk_quiet;
            stall = (snk_quiet || hold_quiet) ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!result_ch.valid);
            model.match_reply(result_ch.kind, result_ch.value, result_ch.last);
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        wr_en             = 1'b0;
        wr_index          = gfcr_pkg::REG_GAP_TICKS;
        wr_data           = 8'h00;
        item_ch.valid     = 1'b0;
        item_ch.command   = gfcr_pkg::CMD_BYTE;
        item_ch.data_byte = 8'h00;
        items_sent        = 0;
        src_quiet         = 1'b0;
        hold_quiet        = 1'b0;
        model = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ack with nothing pending, tick with no frame, unused code
        send_item(gfcr_pkg::CMD_ACK, 8'h00);
        send_item(gfcr_pkg::CMD_IDLE, 8'hFF);
        send_item(CMD_UNUSED, 8'hA5);
        write_reg(gfcr_pkg::REG_GAP_TICKS, 8'd1);
        send_item(gfcr_pkg::CMD_BYTE, 8'h00);
        send_item(gfcr_pkg::CMD_BYTE, 8'hFF);
        send_item(gfcr_pkg::CMD_BYTE, 8'hFF);
        send_item(gfcr_pkg::CMD_IDLE, 8'h00);
        // pending: byte dropped, tick does nothing
        send_item(gfcr_pkg::CMD_BYTE, 8'h12);
        send_item(gfcr_pkg::CMD_IDLE, 8'h00);
        send_item(gfcr_pkg::CMD_ACK, 8'hFF);
        // one-byte frame: NAK carries the stale second byte
        send_item(gfcr_pkg::CMD_BYTE, 8'h80);
        send_item(gfcr_pkg::CMD_IDLE, 8'h00);
        send_frame(3, 1'b0);
        send_item(gfcr_pkg::CMD_BYTE, 8'h03);
        send_item(gfcr_pkg::CMD_BYTE, 8'h04);
        send_item(gfcr_pkg::CMD_BYTE, 8'h00);
        send_item(gfcr_pkg::CMD_IDLE, 8'h00);
        // good frame with zero command: nothing left pending
        send_item(gfcr_pkg::CMD_BYTE, 8'h07);
        send_item(gfcr_pkg::CMD_BYTE, 8'h00);
        send_item(gfcr_pkg::CMD_BYTE, 8'h07);
        send_item(gfcr_pkg::CMD_IDLE, 8'h00);
        // overlong frame
        write_reg(gfcr_pkg::REG_MAX_LEN, 8'd2);
        send_item(gfcr_pkg::CMD_BYTE, 8'h11);
        send_item(gfcr_pkg::CMD_BYTE, 8'h22);
        send_item(gfcr_pkg::CMD_BYTE, 8'h33);
        send_item(gfcr_pkg::CMD_IDLE, 8'h00);
        // gap of zero behaves as one
        configure(8'd0, 8'd16);
        send_item(gfcr_pkg::CMD_BYTE, 8'h40);
        send_item(gfcr_pkg::CMD_BYTE, 8'h40);
        send_item(gfcr_pkg::CMD_IDLE, 8'h00);
        send_item(gfcr_pkg::CMD_ACK, 8'h00);

        configure(gfcr_pkg::GAP_TICKS_RESET, gfcr_pkg::MAX_LEN_RESET);
        random_traffic(25);
        configure(8'd1, 8'd2);
        random_traffic(20);
        configure(8'd0, 8'd1);
        random_traffic(15);
        configure(8'd3, 8'd255);
        random_traffic(25);
        configure(8'd1, 8'd0);
        random_traffic(5);

        // long gap: one frame, handshakes kept tight
        configure(8'd20, 8'd4);
        hold_quiet = 1'b1;
        send_frame(3, 1'b1);
        send_ticks(19);
        send_item(gfcr_pkg::CMD_BYTE, 8'($urandom));
        send_ticks(20);
        send_item(gfcr_pkg::CMD_ACK, 8'($urandom));
        hold_quiet = 1'b0;

        configure(8'd2, 8'd16);
        random_traffic(20);

        item_ch.valid <= 1'b0;
        while (model.outstanding() != 0) @(posedge clk);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (model.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
